FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check, disabled while reset is asserted (active low).
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/ldrs_pkg.sv
// Shared constants, codes and the search token type of the LOOK scheduler.
`timescale 1ns / 1ps
`default_nettype none

package ldrs_pkg;

  // Table geometry
  localparam int Depth  = 64;
  localparam int SlotW  = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);

  // Payload widths
  localparam int TrackW  = 16;
  localparam int TagW    = 16;
  localparam int AgeW    = 16;
  localparam int StatusW = 2;
  localparam int PendW   = 7;

  // Result status codes
  localparam logic [StatusW-1:0] StInserted = 2'd0;
  localparam logic [StatusW-1:0] StServed   = 2'd1;
  localparam logic [StatusW-1:0] StEmpty    = 2'd2;
  localparam logic [StatusW-1:0] StFull     = 2'd3;

  // Candidate classes, lower is preferred
  localparam logic [1:0] ClsSame   = 2'd0;
  localparam logic [1:0] ClsAhead  = 2'd1;
  localparam logic [1:0] ClsBehind = 2'd2;

  // Token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic              live;    // token present in this stage
    logic              serve;   // 1 serve, 0 insert
    logic              hit;     // serve on a non-empty table
    logic              up;      // sweep direction
    logic [TrackW-1:0] track;   // insert track, or head track on serve
    logic [TagW-1:0]   tag;     // insert tag, or served tag picked up
    logic [AgeW-1:0]   ctr;     // arrival counter snapshot
    logic [SlotW-1:0]  head;    // current head slot
    logic              found;   // insert placed, or candidate found
    logic [SlotW-1:0]  slot;    // placed slot, or best candidate slot
    logic [1:0]        bcls;    // best candidate class
    logic [TrackW-1:0] btrack;  // best candidate track
    logic [AgeW-1:0]   bage;    // best candidate age distance
  } token_t;

endpackage

`default_nettype wire

FILE: rtl/ldrs_req_if.sv
// Request channel: one item is an insert or a serve.
`timescale 1ns / 1ps
`default_nettype none

interface ldrs_req_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [ldrs_pkg::TrackW-1:0]    track;
  logic [ldrs_pkg::TagW-1:0]      request_id;

  modport source (output valid, output op, output track, output request_id, input ready);
  modport sink   (input valid, input op, input track, input request_id, output ready);
endinterface

`default_nettype wire

FILE: rtl/ldrs_rsp_if.sv
// Response channel: one result item per request item.
`timescale 1ns / 1ps
`default_nettype none

interface ldrs_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ldrs_pkg::StatusW-1:0]    status;
  logic [ldrs_pkg::TagW-1:0]       served_id;
  logic [ldrs_pkg::TrackW-1:0]     served_track;
  logic [ldrs_pkg::PendW-1:0]      pending;

  modport source (output valid, output status, output served_id, output served_track,
                  output pending, input ready);
  modport sink   (input valid, input status, input served_id, input served_track,
                  input pending, output ready);
endinterface

`default_nettype wire

FILE: rtl/look_disk_request_scheduler.sv
// LOOK elevator scheduler for disk track requests, built as a row of table cells.
//
// Each item, insert or serve, is in flight alone from acceptance until its
// result moves to the output register: a token walks the row of Depth cells,
// one cell per cycle, placing an insert in the lowest free cell or collecting
// the best next head on a serve, and the result register then hands the result
// to the output register. A finished result may wait in the output register
// while the next item is accepted. Configuration writes take effect at once; a
// write while the table is empty also sets the current sweep direction.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module look_disk_request_scheduler (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  ldrs_req_if.sink     req,
  ldrs_rsp_if.source   rsp
);

  ldrs_pkg::token_t                tok_w [ldrs_pkg::Depth+1];
  ldrs_pkg::token_t                launch_tok;
  ldrs_pkg::token_t                exit_tok;

  logic                            busy_q, busy_d;
  logic                            res_v_q, res_v_d;
  logic                            out_v_q, out_v_d;
  logic [ldrs_pkg::CntW-1:0]       held_q, held_d;
  logic [ldrs_pkg::CntW-1:0]       held_dn;
  logic [ldrs_pkg::AgeW-1:0]       ctr_q, ctr_d;
  logic [ldrs_pkg::SlotW-1:0]      head_slot_q, head_slot_d;
  logic [ldrs_pkg::TrackW-1:0]     head_track_q, head_track_d;
  logic                            sweep_q, sweep_d;
  logic                            start_q, start_d;

  logic [ldrs_pkg::StatusW-1:0]    r_status, res_status_q, out_status_q;
  logic [ldrs_pkg::TagW-1:0]       r_id, res_id_q, out_id_q;
  logic [ldrs_pkg::TrackW-1:0]     r_trk, res_trk_q, out_trk_q;
  logic [ldrs_pkg::PendW-1:0]      res_pend_q, out_pend_q;

  logic                            accept, move, serve_hit;

  assign req.ready = !busy_q;
  assign accept    = req.valid && !busy_q;
  assign move      = res_v_q && (!out_v_q || rsp.ready);

  // Launch a token into the first cell
  always_comb begin
    launch_tok        = '0;
    launch_tok.live   = accept;
    launch_tok.serve  = req.op;
    launch_tok.hit    = req.op && (held_q != '0);
    launch_tok.up     = sweep_q;
    launch_tok.track  = req.op ? head_track_q : req.track;
    launch_tok.tag    = req.request_id;
    launch_tok.ctr    = ctr_q;
    launch_tok.head   = head_slot_q;
  end

  assign tok_w[0] = launch_tok;

  // Row of table cells
  for (genvar g = 0; g < ldrs_pkg::Depth; g++) begin : g_cell
    ldrs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (ldrs_pkg::SlotW'(g)),
      .tok_i  (tok_w[g]),
      .tok_o  (tok_w[g+1])
    );
  end

  assign exit_tok  = tok_w[ldrs_pkg::Depth];
  assign serve_hit = exit_tok.live && exit_tok.serve && exit_tok.hit;
  assign held_dn   = held_q - ldrs_pkg::CntW'(1);

  // Retire the token: update scheduler state and form the result
  always_comb begin
    held_d       = held_q;
    ctr_d        = ctr_q;
    head_slot_d  = head_slot_q;
    head_track_d = head_track_q;
    sweep_d      = sweep_q;
    start_d      = start_q;
    r_status     = ldrs_pkg::StFull;
    r_id         = '0;
    r_trk        = '0;
    if (cfg_we_i) begin
      start_d = cfg_wdata_i;
      if (held_q == '0) begin
        sweep_d = cfg_wdata_i;
      end
    end
    if (exit_tok.live) begin
      if (!exit_tok.serve) begin
        if (exit_tok.found) begin
          r_status = ldrs_pkg::StInserted;
          held_d   = held_q + ldrs_pkg::CntW'(1);
          ctr_d    = ctr_q + ldrs_pkg::AgeW'(1);
          if (held_q == '0) begin
            head_slot_d  = exit_tok.slot;
            head_track_d = exit_tok.track;
          end
        end
      end else if (!serve_hit) begin
        r_status = ldrs_pkg::StEmpty;
      end else begin
        r_status = ldrs_pkg::StServed;
        r_id     = exit_tok.tag;
        r_trk    = head_track_q;
        held_d   = held_dn;
        if (exit_tok.found) begin
          head_slot_d  = exit_tok.slot;
          head_track_d = exit_tok.btrack;
          if (exit_tok.bcls == ldrs_pkg::ClsBehind) begin
            sweep_d = !sweep_q;
          end
        end
      end
    end
  end

  // Handshake control: busy from accept until the result reaches the output
  always_comb begin
    busy_d  = busy_q;
    res_v_d = res_v_q;
    out_v_d = out_v_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (exit_tok.live) begin
      res_v_d = 1'b1;
    end else if (move) begin
      res_v_d = 1'b0;
      busy_d  = 1'b0;
    end
    if (move) begin
      out_v_d = 1'b1;
    end else if (rsp.ready) begin
      out_v_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_v_q     <= 1'b0;
      out_v_q     <= 1'b0;
      held_q      <= '0;
      ctr_q       <= '0;
      head_slot_q <= '0;
      sweep_q     <= 1'b1;
      start_q     <= 1'b1;
    end else begin
      busy_q      <= busy_d;
      res_v_q     <= res_v_d;
      out_v_q     <= out_v_d;
      held_q      <= held_d;
      ctr_q       <= ctr_d;
      head_slot_q <= head_slot_d;
      sweep_q     <= sweep_d;
      start_q     <= start_d;
    end
  end

  // Hold head track and result payload
  always_ff @(posedge clk_i) begin
    head_track_q <= head_track_d;
    if (exit_tok.live) begin
      res_status_q <= r_status;
      res_id_q     <= r_id;
      res_trk_q    <= r_trk;
      res_pend_q   <= ldrs_pkg::PendW'(held_d);
    end
    if (move) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_trk_q    <= res_trk_q;
      out_pend_q   <= res_pend_q;
    end
  end

  assign rsp.valid        = out_v_q;
  assign rsp.status       = out_status_q;
  assign rsp.served_id    = out_id_q;
  assign rsp.served_track = out_trk_q;
  assign rsp.pending      = out_pend_q;

  // Checks
  `ASSERT_RST(a_held_bound, clk_i, rst_ni, held_q <= ldrs_pkg::CntW'(ldrs_pkg::Depth), "held overflow")
  `ASSERT_RST(a_exit_busy, clk_i, rst_ni, exit_tok.live |-> busy_q, "token retired while not busy")
  `ASSERT_RST(a_res_busy, clk_i, rst_ni, res_v_q |-> busy_q, "staged result while not busy")
  `ASSERT_RST(a_serve_dec, clk_i, rst_ni, serve_hit |=> held_q == $past(held_dn), "serve miscount")
  `ASSERT_RST(a_no_accept_busy, clk_i, rst_ni, accept |=> !req.ready, "accepted while busy")

endmodule

`default_nettype wire

FILE: rtl/ldrs_cell.sv
// One table entry with its stage of the search token row.
`timescale 1ns / 1ps
`default_nettype none

module ldrs_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ldrs_pkg::SlotW-1:0]   idx_i,
  input  ldrs_pkg::token_t             tok_i,
  output ldrs_pkg::token_t             tok_o
);

  logic                          valid_q, valid_d;
  logic [ldrs_pkg::TrackW-1:0]   track_q, track_d;
  logic [ldrs_pkg::TagW-1:0]     tag_q, tag_d;
  logic [ldrs_pkg::AgeW-1:0]     age_q, age_d;
  ldrs_pkg::token_t              tok_q, tok_d;

  logic                          above, b_above, better;
  logic [1:0]                    cls;
  logic [ldrs_pkg::TrackW-1:0]   trk_dist, bdist;
  logic [ldrs_pkg::AgeW-1:0]     age_dist;

  // Rank this entry against the serve track
  always_comb begin
    above    = track_q > tok_i.track;
    b_above  = tok_i.btrack > tok_i.track;
    trk_dist = above ? (track_q - tok_i.track) : (tok_i.track - track_q);
    bdist    = b_above ? (tok_i.btrack - tok_i.track) : (tok_i.track - tok_i.btrack);
    age_dist = tok_i.ctr - age_q;
    if (track_q == tok_i.track) begin
      cls = ldrs_pkg::ClsSame;
    end else if (above == tok_i.up) begin
      cls = ldrs_pkg::ClsAhead;
    end else begin
      cls = ldrs_pkg::ClsBehind;
    end
    better = !tok_i.found || (cls < tok_i.bcls) ||
             ((cls == tok_i.bcls) &&
              ((trk_dist < bdist) ||
               ((trk_dist == bdist) && (age_dist > tok_i.bage))));
  end

  // Act on the token passing through: place, retire head, or offer a candidate
  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    track_d = track_q;
    tag_d   = tag_q;
    age_d   = age_q;
    if (tok_i.live) begin
      if (!tok_i.serve) begin
        if (!tok_i.found && !valid_q) begin
          valid_d     = 1'b1;
          track_d     = tok_i.track;
          tag_d       = tok_i.tag;
          age_d       = tok_i.ctr;
          tok_d.found = 1'b1;
          tok_d.slot  = idx_i;
        end
      end else if (tok_i.hit) begin
        if (tok_i.head == idx_i) begin
          valid_d   = 1'b0;
          tok_d.tag = tag_q;
        end else if (valid_q && better) begin
          tok_d.found  = 1'b1;
          tok_d.slot   = idx_i;
          tok_d.bcls   = cls;
          tok_d.btrack = track_q;
          tok_d.bage   = age_dist;
        end
      end
    end
  end

  // Hold entry valid flag and the token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Hold entry payload
  always_ff @(posedge clk_i) begin
    track_q <= track_d;
    tag_q   <= tag_d;
    age_q   <= age_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire
